### hdl/erf_pkg.sv
// Shared types, constants and functions for the Ethernet receive filter.
// No dependencies; imported by every module of the block.
package erf_pkg;

  localparam int unsigned CountWidth      = 16;
  localparam int unsigned MacWidth        = 48;
  localparam int unsigned CrcWidth        = 32;
  localparam int unsigned DefMaxFrameBytes = 65535;
  localparam int unsigned HdrBytes        = 14;
  localparam int unsigned MinFrame        = 18;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned OutDataWidth    = 72;

  localparam logic [CrcWidth-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [7:0]          BcastByte = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_NOT_ADDR = 2'd1,
    VERDICT_CRC_ERR  = 2'd2,
    VERDICT_SHORT    = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    PROTO_OTHER = 3'd0,
    PROTO_IPV4  = 3'd1,
    PROTO_ARP   = 3'd2,
    PROTO_RARP  = 3'd3,
    PROTO_SNMP  = 3'd4,
    PROTO_IPX   = 3'd5,
    PROTO_IPV6  = 3'd6,
    PROTO_PPP   = 3'd7
  } proto_e;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [15:0] EtypeRarp = 16'h8035;
  localparam logic [15:0] EtypeSnmp = 16'h814C;
  localparam logic [15:0] EtypeIpx  = 16'h8137;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;
  localparam logic [15:0] EtypePpp  = 16'h880B;

  // End-of-frame summary handed from the front end to the back end.
  typedef struct packed {
    logic                  bcast;
    logic                  local_hit;
    logic [CountWidth-1:0] length;
    logic [15:0]           etype;
    logic [CrcWidth-1:0]   crc;
    logic [CrcWidth-1:0]   fcs;
  } frame_rec_t;

  // One byte of the reflected CRC-32, bit-serial form unrolled.
  function automatic logic [CrcWidth-1:0] crc_byte(logic [CrcWidth-1:0] crc,
                                                   logic [7:0] b);
    logic [CrcWidth-1:0] x;
    x = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return (crc >> 8) ^ x;
  endfunction

  function automatic proto_e classify(logic [15:0] t);
    proto_e p;
    unique case (t)
      EtypeIpv4: p = PROTO_IPV4;
      EtypeArp:  p = PROTO_ARP;
      EtypeRarp: p = PROTO_RARP;
      EtypeSnmp: p = PROTO_SNMP;
      EtypeIpx:  p = PROTO_IPX;
      EtypeIpv6: p = PROTO_IPV6;
      EtypePpp:  p = PROTO_PPP;
      default:   p = PROTO_OTHER;
    endcase
    return p;
  endfunction

endpackage

### hdl/ethernet_frame_rx_filter.sv
// Top level of the Ethernet receive filter with CRC-32 check.
// Depends on erf_pkg, erf_front, erf_fifo and erf_back.
//
// Usage:
//   s_axis: one frame byte per beat in tdata[7:0], tlast on the final byte.
//   m_axis: one result beat per frame, issued for the tlast beat.
//   cfg:    writes the 48-bit station MAC (first wire byte in bits 47:40);
//           always ready, takes effect for address bytes after the write.
// Throughput: one byte per cycle while the record queue has room; the CRC byte
//   update is a combinational xor network in the front end.
// Result path: the tlast beat writes its record into the queue, and the back
//   end output register then raises m_axis_tvalid_o.
// Stalls: results wait in a four-entry record queue and the output
//   register; bytes keep flowing while the queue has room. When it fills
//   (frames much shorter than the downstream drain), s_axis_tready_o drops.
// Reset: async, active low. Per-frame state returns to its idle values,
//   the queue empties, no result is pending and the MAC reads zero.
// Short frames (under 18 bytes) report verdict too short; frame length
//   saturates at MAX_FRAME_BYTES while CRC and FCS tracking keep running.
module ethernet_frame_rx_filter import erf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // byte_value[7:0]
  input  logic [7:0]              s_axis_tdata_i,
  input  logic                    s_axis_tlast_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // verdict[1:0] is_broadcast[2] ethertype[18:3] proto_class[21:19]
  // frame_length[37:22] computed_crc[69:38], zero fill [71:70]
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [MacWidth-1:0]     cfg_data_i
);

  logic [MacWidth-1:0] local_mac_q;
  logic                q_ready, q_push, q_valid, q_pop;
  frame_rec_t          push_rec, head_rec;

  // Station address register; the config channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q <= '0;
    end else if (cfg_valid_i) begin
      local_mac_q <= cfg_data_i;
    end
  end

  erf_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .local_mac_i (local_mac_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .q_ready_i   (q_ready),
    .push_o      (q_push),
    .rec_o       (push_rec)
  );

  erf_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_rec),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_rec)
  );

  erf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (head_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### hdl/erf_front.sv
// Front end: takes frame bytes, tracks address match, ethertype, CRC and FCS.
// Depends on erf_pkg; pushes one frame_rec_t per frame into the queue.
module erf_front import erf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MacWidth-1:0]   local_mac_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  input  logic                  q_ready_i,
  output logic                  push_o,
  output frame_rec_t            rec_o
);

  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_FRAME_BYTES);

  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  bcast_q, bcast_d;
  logic                  local_q, local_d;
  logic [CrcWidth-1:0]   crc_q, crc_d;
  logic [7:0]            tail_q [4];
  logic [15:0]           type_q, type_d;
  logic [7:0]            mac_byte;
  logic                  accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // Address byte expected at this position, first wire byte in the MSBs.
  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    mac_byte = local_mac_i[47:40];
      3'd1:    mac_byte = local_mac_i[39:32];
      3'd2:    mac_byte = local_mac_i[31:24];
      3'd3:    mac_byte = local_mac_i[23:16];
      3'd4:    mac_byte = local_mac_i[15:8];
      default: mac_byte = local_mac_i[7:0];
    endcase
  end

  always_comb begin
    bcast_d = bcast_q;
    local_d = local_q;
    type_d  = type_q;
    crc_d   = crc_q;
    if (cnt_q < CountWidth'(6)) begin
      if (in_byte_i != BcastByte) bcast_d = 1'b0;
      if (in_byte_i != mac_byte)  local_d = 1'b0;
    end else if (cnt_q == CountWidth'(12)) begin
      type_d = {in_byte_i, type_q[7:0]};
    end else if (cnt_q == CountWidth'(13)) begin
      type_d = {type_q[15:8], in_byte_i};
    end
    // The byte leaving the delay line is payload once past header + FCS depth.
    if (cnt_q >= CountWidth'(HdrBytes + 4)) crc_d = crc_byte(crc_q, tail_q[0]);
    cnt_d = (cnt_q < MaxCount) ? cnt_q + CountWidth'(1) : cnt_q;
  end

  assign push_o          = accept && in_last_i;
  assign rec_o.bcast     = bcast_d;
  assign rec_o.local_hit = local_d;
  assign rec_o.length    = cnt_d;
  assign rec_o.etype     = type_d;
  assign rec_o.crc       = crc_d ^ CrcInit;
  assign rec_o.fcs       = {in_byte_i, tail_q[3], tail_q[2], tail_q[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      bcast_q <= 1'b1;
      local_q <= 1'b1;
      crc_q   <= CrcInit;
      type_q  <= '0;
      for (int i = 0; i < 4; i++) tail_q[i] <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        cnt_q   <= '0;
        bcast_q <= 1'b1;
        local_q <= 1'b1;
        crc_q   <= CrcInit;
        type_q  <= '0;
        for (int i = 0; i < 4; i++) tail_q[i] <= '0;
      end else begin
        cnt_q   <= cnt_d;
        bcast_q <= bcast_d;
        local_q <= local_d;
        crc_q   <= crc_d;
        type_q  <= type_d;
        tail_q[0] <= tail_q[1];
        tail_q[1] <= tail_q[2];
        tail_q[2] <= tail_q[3];
        tail_q[3] <= in_byte_i;
      end
    end
  end

endmodule

### hdl/erf_fifo.sv
// Small record queue between the front end and the back end.
// Depends on erf_pkg for frame_rec_t and QueueDepth.
module erf_fifo import erf_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t wdata_i,
  output logic       ready_o,
  input  logic       pop_i,
  output logic       valid_o,
  output frame_rec_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_rec_t          mem_q [DEPTH];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### hdl/erf_back.sv
// Back end: turns a queued frame record into a verdict and registers it.
// Depends on erf_pkg; drives the result stream.
module erf_back import erf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  frame_rec_t              q_rec_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OutDataWidth-1:0] out_data_o
);

  logic                    valid_q;
  logic [OutDataWidth-1:0] data_q, data_d;
  verdict_e                verdict;
  proto_e                  proto;

  always_comb begin
    if (q_rec_i.length < CountWidth'(MinFrame))       verdict = VERDICT_SHORT;
    else if (!q_rec_i.bcast && !q_rec_i.local_hit)    verdict = VERDICT_NOT_ADDR;
    else if (q_rec_i.crc != q_rec_i.fcs)              verdict = VERDICT_CRC_ERR;
    else                                              verdict = VERDICT_OK;
    proto = classify(q_rec_i.etype);
  end

  // verdict[1:0] bcast[2] etype[18:3] proto[21:19] length[37:22] crc[69:38]
  assign data_d = {2'b00, q_rec_i.crc, q_rec_i.length, proto, q_rec_i.etype,
                   q_rec_i.bcast, verdict};

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
